[sv/shsm_pkg.sv]
// ----------------------------------------------------------------------------
// shsm_pkg
// Shared types and codes for the session health state machine.
// ----------------------------------------------------------------------------
package shsm_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned STATE_W = 3;
   localparam int unsigned SIZE_W  = 3;
   localparam int unsigned LAT_W   = 32;
   localparam int unsigned LIM_W   = 8;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
   localparam logic [OP_W-1:0] OP_LOGON      = 3'd1;
   localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd2;
   localparam logic [OP_W-1:0] OP_RECEIVE    = 3'd3;
   localparam logic [OP_W-1:0] OP_TRANSMIT   = 3'd4;
   localparam logic [OP_W-1:0] OP_LATENCY    = 3'd5;
   localparam logic [OP_W-1:0] OP_REJECT     = 3'd6;
   localparam logic [OP_W-1:0] OP_TIMEOUT    = 3'd7;

   localparam logic [STATE_W-1:0] ST_DISCONNECTED = 3'd0;
   localparam logic [STATE_W-1:0] ST_CONNECTING   = 3'd1;
   localparam logic [STATE_W-1:0] ST_LOGGED_IN    = 3'd2;
   localparam logic [STATE_W-1:0] ST_DEGRADED     = 3'd3;
   localparam logic [STATE_W-1:0] ST_HALTED       = 3'd4;

   localparam logic [SIZE_W-1:0] SIZE_NORMAL   = 3'd4;
   localparam logic [SIZE_W-1:0] SIZE_DEGRADED = 3'd1;
   localparam logic [SIZE_W-1:0] SIZE_HALTED   = 3'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_REJECT_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LATENCY_LIMIT = 2'd2;

   localparam logic [LIM_W-1:0] REJECT_LIMIT_RST  = 8'd3;
   localparam logic [LIM_W-1:0] TIMEOUT_LIMIT_RST = 8'd2;
   localparam logic [LAT_W-1:0] LATENCY_LIMIT_RST = 32'd8000;

   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [LAT_W-1:0] latency_value;
   } event_type;

   typedef struct packed {
      logic [LIM_W-1:0] reject_limit;
      logic [LIM_W-1:0] timeout_limit;
      logic [LAT_W-1:0] latency_limit_us;
   } cfg_type;

endpackage

[sv/shsm_req_if.sv]
// ----------------------------------------------------------------------------
// shsm_req_if
// Event channel: valid/ready with operation and latency sample.
// ----------------------------------------------------------------------------
interface shsm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [31:0] latency_value;

   modport source (output valid, output operation, output latency_value, input ready);
   modport sink   (input valid, input operation, input latency_value, output ready);
endinterface

[sv/shsm_rsp_if.sv]
// ----------------------------------------------------------------------------
// shsm_rsp_if
// Result channel: valid/ready with session state and health outputs.
// ----------------------------------------------------------------------------
interface shsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  session_state;
   logic        allow_orders;
   logic [2:0]  size_quarters;
   logic [31:0] latency_average;

   modport source (output valid, output session_state, output allow_orders,
                   output size_quarters, output latency_average, input ready);
   modport sink   (input valid, input session_state, input allow_orders,
                   input size_quarters, input latency_average, output ready);
endinterface

[sv/shsm_csr.sv]
// ----------------------------------------------------------------------------
// shsm_csr
// Limit registers, written through the plain csr write port.
// ----------------------------------------------------------------------------
module shsm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [shsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [shsm_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output shsm_pkg::cfg_type                   cfg
);
   import shsm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REJECT_LIMIT:  cfg_in.reject_limit     = csr_write_data[LIM_W-1:0];
            CSR_TIMEOUT_LIMIT: cfg_in.timeout_limit    = csr_write_data[LIM_W-1:0];
            CSR_LATENCY_LIMIT: cfg_in.latency_limit_us = csr_write_data[LAT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reject_limit     <= REJECT_LIMIT_RST;
         cfg_ff.timeout_limit    <= TIMEOUT_LIMIT_RST;
         cfg_ff.latency_limit_us <= LATENCY_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[sv/shsm_event_reg.sv]
// ----------------------------------------------------------------------------
// shsm_event_reg
// Input register: holds one event until the core takes it.
// ----------------------------------------------------------------------------
module shsm_event_reg (
   input  logic                 clock,
   input  logic                 reset,
   shsm_req_if.sink             req_chan,
   input  logic                 advance,
   output logic                 event_valid,
   output shsm_pkg::event_type  event_data
);
   import shsm_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   event_type data_ff;
   logic      load;

   assign req_chan.ready = !valid_ff || advance;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.operation     <= req_chan.operation;
         data_ff.latency_value <= req_chan.latency_value;
      end
   end

   assign event_valid = valid_ff;
   assign event_data  = data_ff;
endmodule

[sv/shsm_health_core.sv]
// ----------------------------------------------------------------------------
// shsm_health_core
// Session state, counters, latency average and the result register.
// ----------------------------------------------------------------------------
module shsm_health_core (
   input  logic                 clock,
   input  logic                 reset,
   input  shsm_pkg::cfg_type    cfg,
   input  logic                 event_valid,
   input  shsm_pkg::event_type  event_data,
   output logic                 advance,
   shsm_rsp_if.source           rsp_chan
);
   import shsm_pkg::*;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [CNT_W-1:0]   rej_cnt_ff, rej_cnt_in;
   logic [CNT_W-1:0]   to_cnt_ff, to_cnt_in;
   logic [LAT_W-1:0]   avg_ff, avg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] rsp_state_ff;
   logic               rsp_allow_ff;
   logic [SIZE_W-1:0]  rsp_size_ff;
   logic [LAT_W-1:0]   rsp_avg_ff;

   logic [LAT_W+2:0]   avg_sum;
   logic               do_check;
   logic               degrade;
   logic               halt;
   logic [LIM_W:0]     rej_twice;
   logic [LIM_W:0]     to_twice;

   assign advance = event_valid && (!rsp_valid_ff || rsp_chan.ready);

   // 7/8 weighting: 8*avg - avg + sample, 35 bits
   assign avg_sum = {avg_ff, 3'b000} - {3'b000, avg_ff}
                  + {3'b000, event_data.latency_value};

   assign rej_twice = {cfg.reject_limit, 1'b0};
   assign to_twice  = {cfg.timeout_limit, 1'b0};

   always_comb begin
      rej_cnt_in = rej_cnt_ff;
      to_cnt_in  = to_cnt_ff;
      avg_in     = avg_ff;
      state_in   = state_ff;
      do_check   = 1'b0;
      unique case (event_data.operation)
         OP_CONNECT:    state_in = ST_CONNECTING;
         OP_LOGON: begin
            rej_cnt_in = '0;
            to_cnt_in  = '0;
            state_in   = ST_LOGGED_IN;
         end
         OP_DISCONNECT: state_in = ST_DISCONNECTED;
         OP_RECEIVE:    do_check = 1'b1;
         OP_TRANSMIT:   ;
         OP_LATENCY: begin
            avg_in   = avg_sum[LAT_W+2:3];
            do_check = 1'b1;
         end
         OP_REJECT: begin
            if (rej_cnt_ff != COUNT_MAX) rej_cnt_in = rej_cnt_ff + 1'b1;
            do_check = 1'b1;
         end
         OP_TIMEOUT: begin
            if (to_cnt_ff != COUNT_MAX) to_cnt_in = to_cnt_ff + 1'b1;
            do_check = 1'b1;
         end
         default: ;
      endcase

      degrade = (rej_cnt_in >= {{(CNT_W-LIM_W){1'b0}}, cfg.reject_limit})
             || (to_cnt_in >= {{(CNT_W-LIM_W){1'b0}}, cfg.timeout_limit})
             || (avg_in > cfg.latency_limit_us);
      halt    = (rej_cnt_in >= {{(CNT_W-LIM_W-1){1'b0}}, rej_twice})
             || (to_cnt_in >= {{(CNT_W-LIM_W-1){1'b0}}, to_twice});

      if (do_check) begin
         if (state_ff == ST_LOGGED_IN && degrade) begin
            state_in = ST_DEGRADED;
         end else if (state_ff == ST_DEGRADED && halt) begin
            state_in = ST_HALTED;
         end
      end
   end

   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DISCONNECTED;
         rej_cnt_ff   <= '0;
         to_cnt_ff    <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff   <= state_in;
            rej_cnt_ff <= rej_cnt_in;
            to_cnt_ff  <= to_cnt_in;
            avg_ff     <= avg_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff <= state_in;
         rsp_allow_ff <= (state_in == ST_LOGGED_IN) || (state_in == ST_DEGRADED);
         rsp_size_ff  <= (state_in == ST_DEGRADED) ? SIZE_DEGRADED :
                         (state_in == ST_HALTED)   ? SIZE_HALTED : SIZE_NORMAL;
         rsp_avg_ff   <= avg_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.session_state   = rsp_state_ff;
   assign rsp_chan.allow_orders    = rsp_allow_ff;
   assign rsp_chan.size_quarters   = rsp_size_ff;
   assign rsp_chan.latency_average = rsp_avg_ff;

   a_logon_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && event_data.operation == OP_LOGON) |=> (rej_cnt_ff == '0 && to_cnt_ff == '0))
      else $error("counters not cleared by logon");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(state_ff))
      else $error("session state moved while result stalled");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(advance)) |-> (rsp_chan.session_state == state_ff))
      else $error("result state differs from session state");

   a_halt_from_degraded: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && state_ff == ST_HALTED && $past(state_ff) != ST_HALTED)
         |-> ($past(state_ff) == ST_DEGRADED))
      else $error("halted reached from a state other than degraded");
endmodule

[sv/session_health_state_machine_top.sv]
// ----------------------------------------------------------------------------
// session_health_state_machine_top
// Trading link session health tracker: state, counters, latency average.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready        operation, latency_value
//   rsp_chan   out   valid/ready        session_state, allow_orders,
//                                       size_quarters, latency_average
//   csr_*      in    write enable only  csr_index, csr_write_data
//
// One event per cycle sustained while rsp_chan is ready; each event passes
// the input register, then the result register holding the update, before
// its result is valid on rsp_chan.
// Synchronous active-high reset: disconnected, counters and average zero,
// limits 3 / 2 / 8000.
// A stalled result holds the core; the input register still takes one event.
// ----------------------------------------------------------------------------
module session_health_state_machine_top (
   input  logic                             clock,
   input  logic                             reset,
   shsm_req_if.sink                         req_chan,
   shsm_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [shsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shsm_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import shsm_pkg::*;

   cfg_type   cfg;
   event_type event_data;
   logic      event_valid;
   logic      advance;

   shsm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   shsm_event_reg u_event_reg (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .advance     (advance),
      .event_valid (event_valid),
      .event_data  (event_data)
   );

   shsm_health_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .event_valid (event_valid),
      .event_data  (event_data),
      .advance     (advance),
      .rsp_chan    (rsp_chan)
   );
endmodule
